@@ rtl/core/dpb_pkg.sv @@
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants for the depth pixel back-projector
// Field widths, register indexes, pose word codes and saturation helpers.
// ----------------------------------------------------------------------------
package dpb_pkg;

	// fixed-point widths
	localparam int QW   = 18;   // quaternion word, Q1.16
	localparam int TW   = 24;   // translation / pose value, Q8.16
	localparam int RW   = 22;   // rotation matrix entry, Q.16
	localparam int DW   = 32;   // camera-frame point after offset, Q16.16
	localparam int CW   = 24;   // world coordinate, Q8.16
	localparam int PXW  = 46;   // camera x/y before saturation
	localparam int CIDW = 3;    // config register index

	localparam logic signed [QW-1:0] Q_ONE = 18'sd65536;
	localparam logic signed [RW-1:0] R_ONE = 22'sd65536;

	// config register indexes
	typedef enum logic [CIDW-1:0] {
		CFG_CENTER_X        = 3'd0,
		CFG_CENTER_Y        = 3'd1,
		CFG_INV_FOCAL_X     = 3'd2,
		CFG_INV_FOCAL_Y     = 3'd3,
		CFG_INV_DEPTH_SCALE = 3'd4
	} cfg_idx_e;

	// item kinds
	localparam logic KIND_POSE  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	// pose word indexes
	localparam logic [2:0] PIDX_QW = 3'd0;
	localparam logic [2:0] PIDX_QX = 3'd1;
	localparam logic [2:0] PIDX_QY = 3'd2;
	localparam logic [2:0] PIDX_QZ = 3'd3;
	localparam logic [2:0] PIDX_TX = 3'd4;
	localparam logic [2:0] PIDX_TY = 3'd5;
	localparam logic [2:0] PIDX_TZ = 3'd6;

	typedef struct packed {
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [23:0] inv_focal_x;
		logic [23:0] inv_focal_y;
		logic [31:0] inv_depth_scale;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic                 kind;
		logic [2:0]           pose_index;
		logic signed [TW-1:0] pose_value;
		logic [11:0]          column;
		logic [11:0]          row;
		logic [15:0]          depth;
		rgb_t                 colour;
	} item_t;

	// quaternion word write, leaves the first stage
	typedef struct packed {
		logic                 valid;
		logic [1:0]           idx;
		logic signed [TW-1:0] value;
	} pose_wr_t;

	// camera-frame point leaving stage 3
	typedef struct packed {
		logic                  valid;
		logic                  emit;
		logic                  kind;
		logic [2:0]            pose_index;
		logic signed [TW-1:0]  pose_value;
		rgb_t                  colour;
		logic signed [PXW-1:0] px;
		logic signed [PXW-1:0] py;
		logic [31:0]           scale;
	} cam_t;

	typedef logic signed [RW-1:0] rent_t;
	typedef rent_t [2:0][2:0] rmat_t;   // [row][col]

	typedef struct packed {
		logic signed [CW-1:0] world_x;
		logic signed [CW-1:0] world_y;
		logic signed [CW-1:0] world_z;
		rgb_t                 colour;
	} res_t;

	function automatic logic signed [QW-1:0] sat_q18(input logic signed [TW-1:0] v);
		logic signed [QW-1:0] r;
		if (v[TW-1:QW-1] == {(TW-QW+1){v[TW-1]}})
			r = v[QW-1:0];
		else
			r = v[TW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
		return r;
	endfunction

	function automatic logic signed [DW-1:0] sat_d46(input logic signed [PXW-1:0] v);
		logic signed [DW-1:0] r;
		if (v[PXW-1:DW-1] == {(PXW-DW+1){v[PXW-1]}})
			r = v[DW-1:0];
		else
			r = v[PXW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		return r;
	endfunction

	function automatic logic signed [DW-1:0] sat_d33(input logic signed [DW:0] v);
		logic signed [DW-1:0] r;
		if (v[DW] == v[DW-1])
			r = v[DW-1:0];
		else
			r = v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		return r;
	endfunction

	function automatic logic signed [CW-1:0] sat_c40(input logic signed [39:0] v);
		logic signed [CW-1:0] r;
		if (v[39:CW-1] == {(40-CW+1){v[39]}})
			r = v[CW-1:0];
		else
			r = v[39] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		return r;
	endfunction

endpackage

@@ rtl/core/dpb_ifs.sv @@
// ----------------------------------------------------------------------------
// dpb_ifs: channel interfaces of the depth pixel back-projector
// Pixel/pose input channel, point output channel and config write channel.
// ----------------------------------------------------------------------------
interface dpb_pixel_if;
	import dpb_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [2:0]           pose_index;
	logic signed [TW-1:0] pose_value;
	logic [11:0]          column;
	logic [11:0]          row;
	logic [15:0]          depth;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;

	modport source(output valid, kind, pose_index, pose_value, column, row, depth,
		red, green, blue, input ready);
	modport sink(input valid, kind, pose_index, pose_value, column, row, depth,
		red, green, blue, output ready);
endinterface

interface dpb_point_if;
	import dpb_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] world_x;
	logic signed [CW-1:0] world_y;
	logic signed [CW-1:0] world_z;
	logic [7:0]           point_red;
	logic [7:0]           point_green;
	logic [7:0]           point_blue;

	modport source(output valid, world_x, world_y, world_z, point_red, point_green,
		point_blue, input ready);
	modport sink(input valid, world_x, world_y, world_z, point_red, point_green,
		point_blue, output ready);
endinterface

interface dpb_cfg_if;
	import dpb_pkg::*;
	logic            valid;
	logic            ready;
	logic [CIDW-1:0] index;
	logic [31:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/dpb_cam.sv @@
// ----------------------------------------------------------------------------
// dpb_cam: stages 1 to 3, pixel to camera-frame point
// Offsets from the principal point, depth scale, then x/y times scale.
// ----------------------------------------------------------------------------
module dpb_cam (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             acc,
	input  dpb_pkg::item_t   item,
	input  dpb_pkg::cfg_t    regs,
	output dpb_pkg::pose_wr_t qwr,
	output dpb_pkg::cam_t    cam
);
	import dpb_pkg::*;

	// stage 1
	logic                 valid_s1;
	logic                 kind_s1;
	logic [2:0]           idx_s1;
	logic signed [TW-1:0] pval_s1;
	logic [15:0]          depth_s1;
	rgb_t                 rgb_s1;
	logic signed [17:0]   du_s1, dv_s1;
	// stage 2
	logic                 valid_s2, emit_s2, kind_s2;
	logic [2:0]           idx_s2;
	logic signed [TW-1:0] pval_s2;
	rgb_t                 rgb_s2;
	logic [31:0]          scale_s2;
	logic signed [29:0]   ax_s2, ay_s2;
	// stage 3
	logic                  valid_s3, emit_s3, kind_s3;
	logic [2:0]            idx_s3;
	logic signed [TW-1:0]  pval_s3;
	rgb_t                  rgb_s3;
	logic [31:0]           scale_s3;
	logic signed [PXW-1:0] px_s3, py_s3;

	logic signed [17:0] du_c, dv_c;
	logic [47:0]        sprod_c;
	logic signed [42:0] axp_c, ayp_c;
	logic signed [62:0] pxp_c, pyp_c;

	// Q12.4 offsets from the principal point
	assign du_c = $signed({2'b00, item.column, 4'b0000}) - $signed({2'b00, regs.center_x});
	assign dv_c = $signed({2'b00, item.row, 4'b0000}) - $signed({2'b00, regs.center_y});

	assign sprod_c = depth_s1 * regs.inv_depth_scale;
	assign axp_c   = du_s1 * $signed({1'b0, regs.inv_focal_x});
	assign ayp_c   = dv_s1 * $signed({1'b0, regs.inv_focal_y});

	assign pxp_c = ax_s2 * $signed({1'b0, scale_s2});
	assign pyp_c = ay_s2 * $signed({1'b0, scale_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1  <= item.kind;
			idx_s1   <= item.pose_index;
			pval_s1  <= item.pose_value;
			depth_s1 <= item.depth;
			rgb_s1   <= item.colour;
			du_s1    <= du_c;
			dv_s1    <= dv_c;

			emit_s2  <= (kind_s1 == KIND_PIXEL) && (depth_s1 != 16'd0);
			kind_s2  <= kind_s1;
			idx_s2   <= idx_s1;
			pval_s2  <= pval_s1;
			rgb_s2   <= rgb_s1;
			scale_s2 <= sprod_c[47:16];
			ax_s2    <= axp_c[41:12];
			ay_s2    <= ayp_c[41:12];

			emit_s3  <= emit_s2;
			kind_s3  <= kind_s2;
			idx_s3   <= idx_s2;
			pval_s3  <= pval_s2;
			rgb_s3   <= rgb_s2;
			scale_s3 <= scale_s2;
			px_s3    <= pxp_c[61:16];
			py_s3    <= pyp_c[61:16];
		end
	end

	// quaternion words take effect as they leave stage 1
	assign qwr.valid = valid_s1 && (kind_s1 == KIND_POSE) &&
		(idx_s1 inside {[PIDX_QW:PIDX_QZ]});
	assign qwr.idx   = idx_s1[1:0];
	assign qwr.value = pval_s1;

	assign cam.valid      = valid_s3;
	assign cam.emit       = emit_s3;
	assign cam.kind       = kind_s3;
	assign cam.pose_index = idx_s3;
	assign cam.pose_value = pval_s3;
	assign cam.colour     = rgb_s3;
	assign cam.px         = px_s3;
	assign cam.py         = py_s3;
	assign cam.scale      = scale_s3;

endmodule

@@ rtl/core/dpb_rot.sv @@
// ----------------------------------------------------------------------------
// dpb_rot: quaternion store and rotation matrix build
// Quaternion products, then the matrix entries; both registered.
// ----------------------------------------------------------------------------
module dpb_rot (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  dpb_pkg::pose_wr_t qwr,
	output dpb_pkg::rmat_t    rmat
);
	import dpb_pkg::*;

	logic signed [QW-1:0] quat_q [4];   // w, x, y, z
	logic signed [2*QW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
	rmat_t rmat_q;

	// floor((a +/- b) * 2 / 2^16)
	function automatic rent_t half(input logic signed [2*QW-1:0] a,
		input logic signed [2*QW-1:0] b, input logic neg);
		logic signed [2*QW:0] s;
		s = neg ? ({a[2*QW-1], a} - {b[2*QW-1], b}) : ({a[2*QW-1], a} + {b[2*QW-1], b});
		return s[RW+14:15];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q[0] <= Q_ONE;
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= '0;
		end else if (en && qwr.valid) begin
			quat_q[qwr.idx] <= sat_q18(qwr.value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xx_q <= '0; yy_q <= '0; zz_q <= '0;
			xy_q <= '0; xz_q <= '0; yz_q <= '0;
			wx_q <= '0; wy_q <= '0; wz_q <= '0;
		end else if (en) begin
			xx_q <= quat_q[1] * quat_q[1];
			yy_q <= quat_q[2] * quat_q[2];
			zz_q <= quat_q[3] * quat_q[3];
			xy_q <= quat_q[1] * quat_q[2];
			xz_q <= quat_q[1] * quat_q[3];
			yz_q <= quat_q[2] * quat_q[3];
			wx_q <= quat_q[0] * quat_q[1];
			wy_q <= quat_q[0] * quat_q[2];
			wz_q <= quat_q[0] * quat_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// identity; rows listed from [2] down to [0]
			rmat_q <= '{'{R_ONE, '0, '0}, '{'0, R_ONE, '0}, '{'0, '0, R_ONE}};
		end else if (en) begin
			rmat_q[0][0] <= R_ONE - half(yy_q, zz_q, 1'b0);
			rmat_q[0][1] <= half(xy_q, wz_q, 1'b1);
			rmat_q[0][2] <= half(xz_q, wy_q, 1'b0);
			rmat_q[1][0] <= half(xy_q, wz_q, 1'b0);
			rmat_q[1][1] <= R_ONE - half(xx_q, zz_q, 1'b0);
			rmat_q[1][2] <= half(yz_q, wx_q, 1'b1);
			rmat_q[2][0] <= half(xz_q, wy_q, 1'b1);
			rmat_q[2][1] <= half(yz_q, wx_q, 1'b0);
			rmat_q[2][2] <= R_ONE - half(xx_q, yy_q, 1'b0);
		end
	end

	assign rmat = rmat_q;

endmodule

@@ rtl/core/dpb_world.sv @@
// ----------------------------------------------------------------------------
// dpb_world: stages 4 and 5, camera point to world point
// Translation offset, matrix products, then the sum feeding the output queue.
// ----------------------------------------------------------------------------
module dpb_world (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  dpb_pkg::cam_t  cam,
	input  dpb_pkg::rmat_t rmat,
	output logic           emit,
	output dpb_pkg::res_t  res
);
	import dpb_pkg::*;

	logic signed [TW-1:0] trans_q [3];

	logic                 valid_s4, emit_s4;
	rgb_t                 rgb_s4;
	logic signed [DW-1:0] d_s4 [3];

	logic                 valid_s5, emit_s5;
	rgb_t                 rgb_s5;
	logic signed [RW+DW-1:0] prod_s5 [3][3];   // [col][row]

	logic signed [DW-1:0] pc_c [3];
	logic signed [DW-1:0] d_c  [3];
	logic signed [RW+DW+1:0] acc_c [3];
	logic signed [CW-1:0] wc_c [3];
	logic twr_c;

	assign pc_c[0] = sat_d46(cam.px);
	assign pc_c[1] = sat_d46(cam.py);
	assign pc_c[2] = cam.scale[31] ? {1'b0, {(DW-1){1'b1}}} : $signed(cam.scale);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = sat_d33({pc_c[i][DW-1], pc_c[i]} -
				{{(DW+1-TW){trans_q[i][TW-1]}}, trans_q[i]});
		end
	end

	// translation words take effect as they leave stage 3
	assign twr_c = en && cam.valid && (cam.kind == KIND_POSE) &&
		(cam.pose_index inside {[PIDX_TX:PIDX_TZ]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_q[0] <= '0;
			trans_q[1] <= '0;
			trans_q[2] <= '0;
		end else if (twr_c) begin
			trans_q[cam.pose_index[1:0]] <= cam.pose_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= cam.valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			emit_s4 <= cam.emit;
			rgb_s4  <= cam.colour;
			for (int i = 0; i < 3; i++)
				d_s4[i] <= d_c[i];

			emit_s5 <= emit_s4;
			rgb_s5  <= rgb_s4;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					prod_s5[i][j] <= $signed(rmat[j][i]) * d_s4[j];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_c[i] = {{2{prod_s5[i][0][RW+DW-1]}}, prod_s5[i][0]} +
				{{2{prod_s5[i][1][RW+DW-1]}}, prod_s5[i][1]} +
				{{2{prod_s5[i][2][RW+DW-1]}}, prod_s5[i][2]};
			wc_c[i] = sat_c40(acc_c[i][RW+DW+1:16]);
		end
	end

	assign emit        = valid_s5 && emit_s5;
	assign res.world_x = wc_c[0];
	assign res.world_y = wc_c[1];
	assign res.world_z = wc_c[2];
	assign res.colour  = rgb_s5;

endmodule

@@ rtl/core/depth_pixel_backproject.sv @@
// ----------------------------------------------------------------------------
// depth_pixel_backproject: depth pixel to world point, five-stage pipeline
// Back-projects depth pixels through stored intrinsics and an inverted pose.
//
//  channel | dir | handshake     | carries
//  --------+-----+---------------+---------------------------------------------
//  pixel   | in  | valid / ready | pose word load or depth pixel with colour
//  point   | out | valid / ready | world x/y/z (Q8.16, saturated) and colour
//  cfg     | in  | valid / ready | register index and write data
//
//  One request is taken per cycle unless the pipe stalls. A pixel's point
//  passes stages 1 to 5 (offsets, depth and focal scale, x/y scale,
//  translation, rotation products), with a register after each multiplier,
//  and then the output queue register before it shows on the point channel.
//  Reset: config registers zero, pose identity with zero translation, pipe
//  empty; no start-up sweep. The config port is always ready.
//  Stalls: the whole pipe holds only when both output queue slots are full
//  and the sink is not ready; one queued point never blocks new requests.
// ----------------------------------------------------------------------------
module depth_pixel_backproject (
	input logic          clk,
	input logic          arst_n,
	dpb_pixel_if.sink    pixel,
	dpb_point_if.source  point,
	dpb_cfg_if.sink      cfg
);
	import dpb_pkg::*;

	cfg_t     regs_q;       // intrinsics and depth scale
	item_t    item;
	pose_wr_t qwr;
	cam_t     cam;
	rmat_t    rmat;
	res_t     res;
	res_t     ent0_q, ent1_q;   // output queue, ent0_q is the head
	logic [1:0] cnt_q;
	logic     en, acc, emit, push, pop;

	// ---- config registers ---------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_CENTER_X:        regs_q.center_x        <= cfg.data[15:0];
				CFG_CENTER_Y:        regs_q.center_y        <= cfg.data[15:0];
				CFG_INV_FOCAL_X:     regs_q.inv_focal_x     <= cfg.data[23:0];
				CFG_INV_FOCAL_Y:     regs_q.inv_focal_y     <= cfg.data[23:0];
				CFG_INV_DEPTH_SCALE: regs_q.inv_depth_scale <= cfg.data;
				default: ;   // unused index, ignored
			endcase
		end
	end

	// ---- pipe advance -------------------------------------------------------
	// the pipe moves unless the queue is full with no pop
	assign en          = (cnt_q != 2'd2) || point.ready;
	assign pixel.ready = en;
	assign acc         = pixel.valid && en;

	assign item.kind       = pixel.kind;
	assign item.pose_index = pixel.pose_index;
	assign item.pose_value = pixel.pose_value;
	assign item.column     = pixel.column;
	assign item.row        = pixel.row;
	assign item.depth      = pixel.depth;
	assign item.colour     = '{red: pixel.red, green: pixel.green, blue: pixel.blue};

	// stages 1-3: offsets, depth scale, camera-frame point
	dpb_cam u_cam (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.acc    (acc),
		.item   (item),
		.regs   (regs_q),
		.qwr    (qwr),
		.cam    (cam)
	);

	// quaternion writes leave stage 1 and pass the product and matrix registers,
	// so a pixel reads the matrix at stage 4 in step with the pose words around it
	dpb_rot u_rot (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.qwr    (qwr),
		.rmat   (rmat)
	);

	// stages 4-5: translation, matrix products; sum and saturate into queue
	dpb_world u_world (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cam    (cam),
		.rmat   (rmat),
		.emit   (emit),
		.res    (res)
	);

	// ---- output queue, two entries ------------------------------------------
	// pose words and zero-depth pixels drop out here
	assign push = en && emit;
	assign pop  = point.valid && point.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: begin
				if (push)
					ent0_q <= res;
			end
			2'd1: begin
				if (push && pop)
					ent0_q <= res;
				else if (push)
					ent1_q <= res;
			end
			2'd2: begin
				if (pop) begin
					ent0_q <= ent1_q;
					if (push)
						ent1_q <= res;
				end
			end
			default: ;
		endcase
	end

	assign point.valid       = (cnt_q != 2'd0);
	assign point.world_x     = ent0_q.world_x;
	assign point.world_y     = ent0_q.world_y;
	assign point.world_z     = ent0_q.world_z;
	assign point.point_red   = ent0_q.colour.red;
	assign point.point_green = ent0_q.colour.green;
	assign point.point_blue  = ent0_q.colour.blue;

	// ---- checks -------------------------------------------------------------
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !point.ready) |-> !pixel.ready)
		else $error("request taken with full output queue");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cnt_q == 2'd2) |-> pop)
		else $error("output queue overflow");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (cnt_q == ($past(cnt_q) + {1'b0, $past(push)} - {1'b0, $past(pop)})))
		else $error("output queue count out of step");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |=> (cnt_q != 2'd2))
		else $error("output queue filled twice in one cycle");

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for depth_pixel_backproject
// Drives pose-word loads and depth pixels through the pixel channel, writes
// the intrinsics through the cfg channel while the pipe is idle, and checks
// every point against an in-bench fixed-point back-projection of the same
// requests. Both channel ends idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dpb_pkg::*;

	// pose index with no word behind it; such loads are dropped
	localparam logic [2:0] PIDX_UNUSED = 3'd7;
	// pipe depth plus output queue, with margin; used before cfg writes and at the end
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_MAX    = 10;
	localparam int ITEM_W        = $bits(item_t);

	logic clk;
	logic arst_n;

	dpb_pixel_if pixel_ch ();
	dpb_point_if point_ch ();
	dpb_cfg_if   cfg_ch ();

	depth_pixel_backproject dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_ch),
		.point  (point_ch),
		.cfg    (cfg_ch)
	);

	// ------------------------------------------------------------------
	// Shadow copy of the block's state: intrinsics and stored pose
	// ------------------------------------------------------------------
	longint principal_u, principal_v;   // Q12.4
	longint recip_fx, recip_fy;         // Q0.24
	longint metres_per_count;           // Q0.32
	longint pose_q [4];                 // Q1.16 w, x, y, z
	longint pose_t [3];                 // Q8.16 x, y, z

	res_t expected_points [$];

	int fault_count;
	int cycle_count;
	bit send_unpaced;   // sender runs without gaps for a stretch
	bit sink_unpaced;   // sink keeps ready high for a stretch

	// ------------------------------------------------------------------
	// Clock, cycle limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("depth_pixel_backproject verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Fixed-point helpers for the predictor
	// ------------------------------------------------------------------
	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint clip32(longint v);
		return clip(v, -64'sd2147483648, 64'sd2147483647);
	endfunction

	function automatic longint clip24(longint v);
		return clip(v, -64'sd8388608, 64'sd8388607);
	endfunction

	// Updates the shadow pose for a load, or works out the world point for a
	// pixel and queues it. Arithmetic right shifts on longint are floors.
	function automatic void backproject_request(item_t it);
		longint scale, du, dv, w, x, y, z, acc;
		longint cam [3];
		longint rel [3];
		longint rot [3][3];
		longint world [3];
		res_t pt;
		if (it.kind == KIND_POSE) begin
			if (it.pose_index <= PIDX_QZ)
				pose_q[it.pose_index] = clip(longint'($signed(it.pose_value)),
					-64'sd131072, 64'sd131071);
			else if (it.pose_index <= PIDX_TZ)
				pose_t[it.pose_index - PIDX_TX] = longint'($signed(it.pose_value));
			return;
		end
		if (it.depth == 16'd0)
			return;

		// camera frame: scale is Q16.16 metres
		scale  = (longint'(it.depth) * metres_per_count) >>> 16;
		du     = longint'(it.column) * 16 - principal_u;
		dv     = longint'(it.row) * 16 - principal_v;
		cam[0] = clip32((((du * recip_fx) >>> 12) * scale) >>> 16);
		cam[1] = clip32((((dv * recip_fy) >>> 12) * scale) >>> 16);
		cam[2] = clip32(scale);
		for (int i = 0; i < 3; i++)
			rel[i] = clip32(cam[i] - pose_t[i]);

		// rotation from the stored quaternion, no normalisation
		w = pose_q[0];
		x = pose_q[1];
		y = pose_q[2];
		z = pose_q[3];
		rot[0][0] = 65536 - ((2 * (y * y + z * z)) >>> 16);
		rot[0][1] = (2 * (x * y - w * z)) >>> 16;
		rot[0][2] = (2 * (x * z + w * y)) >>> 16;
		rot[1][0] = (2 * (x * y + w * z)) >>> 16;
		rot[1][1] = 65536 - ((2 * (x * x + z * z)) >>> 16);
		rot[1][2] = (2 * (y * z - w * x)) >>> 16;
		rot[2][0] = (2 * (x * z - w * y)) >>> 16;
		rot[2][1] = (2 * (y * z + w * x)) >>> 16;
		rot[2][2] = 65536 - ((2 * (x * x + y * y)) >>> 16);

		// world = R^T * rel
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += rot[j][i] * rel[j];
			world[i] = clip24(acc >>> 16);
		end
		pt.world_x = world[0][CW-1:0];
		pt.world_y = world[1][CW-1:0];
		pt.world_z = world[2][CW-1:0];
		pt.colour  = it.colour;
		expected_points = {expected_points, pt};
	endfunction

	// ------------------------------------------------------------------
	// Request builders; fields the block ignores are randomised so their
	// bits toggle too
	// ------------------------------------------------------------------
	function automatic item_t pose_word(logic [2:0] idx, logic signed [TW-1:0] value);
		item_t it;
		it            = item_t'(ITEM_W'({$urandom(), $urandom(), $urandom()}));
		it.kind       = KIND_POSE;
		it.pose_index = idx;
		it.pose_value = value;
		return it;
	endfunction

	function automatic item_t depth_pixel(logic [11:0] u, logic [11:0] v, logic [15:0] d,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		item_t it;
		it              = item_t'(ITEM_W'({$urandom(), $urandom(), $urandom()}));
		it.kind         = KIND_PIXEL;
		it.column       = u;
		it.row          = v;
		it.depth        = d;
		it.colour.red   = r;
		it.colour.green = g;
		it.colour.blue  = b;
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Channel tasks
	// ------------------------------------------------------------------

	// One request on the pixel channel. Valid is left high after acceptance;
	// the next call either keeps it up with new data or drops it for a gap.
	task automatic send_request(item_t it);
		int gap;
		if ($urandom_range(0, 63) == 0)
			send_unpaced = !send_unpaced;
		gap = send_unpaced ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			pixel_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_ch.valid      <= 1'b1;
		pixel_ch.kind       <= it.kind;
		pixel_ch.pose_index <= it.pose_index;
		pixel_ch.pose_value <= it.pose_value;
		pixel_ch.column     <= it.column;
		pixel_ch.row        <= it.row;
		pixel_ch.depth      <= it.depth;
		pixel_ch.red        <= it.colour.red;
		pixel_ch.green      <= it.colour.green;
		pixel_ch.blue       <= it.colour.blue;
		@(posedge clk);
		while (!pixel_ch.ready) @(posedge clk);
		backproject_request(it);
	endtask

	// always waits for the clock before it checks, so valid is never driven twice at once
	task automatic wait_points_drained();
		pixel_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_points.size() != 0) @(posedge clk);
	endtask

	// pose loads and zero-depth pixels may still be in flight with nothing expected
	task automatic wait_idle();
		wait_points_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves valid high; the caller drops it after the last write
	task automatic write_register(cfg_idx_e idx, logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			CFG_CENTER_X:        principal_u      = longint'(data[15:0]);
			CFG_CENTER_Y:        principal_v      = longint'(data[15:0]);
			CFG_INV_FOCAL_X:     recip_fx         = longint'(data[23:0]);
			CFG_INV_FOCAL_Y:     recip_fy         = longint'(data[23:0]);
			CFG_INV_DEPTH_SCALE: metres_per_count = longint'(data);
			default: ;
		endcase
	endtask

	// all five intrinsics; upper bits beyond each register's width are junk
	task automatic set_intrinsics(logic [15:0] cx, logic [15:0] cy, logic [23:0] fx,
			logic [23:0] fy, logic [31:0] mpc);
		wait_idle();
		write_register(CFG_CENTER_X,        {16'($urandom_range(0, 65535)), cx});
		write_register(CFG_CENTER_Y,        {16'($urandom_range(0, 65535)), cy});
		write_register(CFG_INV_FOCAL_X,     {8'($urandom_range(0, 255)), fx});
		write_register(CFG_INV_FOCAL_Y,     {8'($urandom_range(0, 255)), fy});
		write_register(CFG_INV_DEPTH_SCALE, mpc);
		cfg_ch.valid <= 1'b0;
	endtask

	// well-formed pose update: unit quaternion about a random axis, plus a
	// translation within a few metres
	task automatic load_random_pose();
		real ax, ay, az, nrm, ang, sh;
		logic signed [TW-1:0] qw, qx, qy, qz;
		ax  = $urandom_range(0, 2000) / 1000.0 - 1.0;
		ay  = $urandom_range(0, 2000) / 1000.0 - 1.0;
		az  = $urandom_range(0, 2000) / 1000.0 - 1.0;
		nrm = $sqrt(ax * ax + ay * ay + az * az);
		if (nrm < 0.001) begin
			ax  = 1.0;
			nrm = 1.0;
		end
		ang = $urandom_range(0, 62831) / 10000.0;
		sh  = $sin(ang / 2.0) / nrm;
		qw  = TW'($rtoi($cos(ang / 2.0) * 65536.0));
		qx  = TW'($rtoi(ax * sh * 65536.0));
		qy  = TW'($rtoi(ay * sh * 65536.0));
		qz  = TW'($rtoi(az * sh * 65536.0));
		send_request(pose_word(PIDX_QW, qw));
		send_request(pose_word(PIDX_QX, qx));
		send_request(pose_word(PIDX_QY, qy));
		send_request(pose_word(PIDX_QZ, qz));
		send_request(pose_word(PIDX_TX, TW'(int'($urandom_range(0, 524288)) - 262144)));
		send_request(pose_word(PIDX_TY, TW'(int'($urandom_range(0, 524288)) - 262144)));
		send_request(pose_word(PIDX_TZ, TW'(int'($urandom_range(0, 524288)) - 262144)));
	endtask

	// ------------------------------------------------------------------
	// Point sink: random stall before each point, with unstalled stretches
	// ------------------------------------------------------------------
	initial begin
		int stall;
		point_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0)
				sink_unpaced = !sink_unpaced;
			stall = sink_unpaced ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				point_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			point_ch.ready <= 1'b1;
			@(posedge clk);
			while (!point_ch.valid) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Point checker: each accepted point against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		res_t want;
		if (arst_n && point_ch.valid && point_ch.ready) begin
			if (expected_points.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX)
					$display("unexpected point x=%0d y=%0d z=%0d rgb=%02x%02x%02x",
						$signed(point_ch.world_x), $signed(point_ch.world_y),
						$signed(point_ch.world_z), point_ch.point_red,
						point_ch.point_green, point_ch.point_blue);
			end else begin
				want = expected_points.pop_front();
				if (point_ch.world_x !== want.world_x || point_ch.world_y !== want.world_y ||
						point_ch.world_z !== want.world_z ||
						point_ch.point_red !== want.colour.red ||
						point_ch.point_green !== want.colour.green ||
						point_ch.point_blue !== want.colour.blue) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("point mismatch: want x=%0d y=%0d z=%0d rgb=%02x%02x%02x, got x=%0d y=%0d z=%0d rgb=%02x%02x%02x",
							$signed(want.world_x), $signed(want.world_y),
							$signed(want.world_z), want.colour.red, want.colour.green,
							want.colour.blue, $signed(point_ch.world_x),
							$signed(point_ch.world_y), $signed(point_ch.world_z),
							point_ch.point_red, point_ch.point_green,
							point_ch.point_blue);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset intrinsics are all zero: every point collapses onto -t = origin
	task automatic test_zero_config();
		send_request(depth_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		send_request(depth_pixel(12'h000, 12'h000, 16'h0001, 8'h00, 8'h00, 8'h00));
		send_request(depth_pixel(12'h5A5, 12'hA5A, 16'h0000, 8'h12, 8'h34, 8'h56));
	endtask

	// every pose word, quaternion saturation both ways, unused index dropped;
	// the result is a non-unit quaternion and extreme translation
	task automatic test_pose_words();
		send_request(pose_word(PIDX_QW, 24'sd8388607));
		send_request(pose_word(PIDX_QX, -24'sd8388608));
		send_request(pose_word(PIDX_QY, 24'sd131071));
		send_request(pose_word(PIDX_QZ, -24'sd131073));
		send_request(pose_word(PIDX_TX, 24'sd8388607));
		send_request(pose_word(PIDX_TY, -24'sd8388608));
		send_request(pose_word(PIDX_TZ, 24'sd65536));
		send_request(pose_word(PIDX_UNUSED, 24'sd12345));
		send_request(depth_pixel(12'd100, 12'd200, 16'd5000, 8'hAA, 8'h55, 8'h0F));
	endtask

	// intrinsics at their top values, with saturating camera and world coords
	task automatic test_config_extremes();
		set_intrinsics(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
		send_request(depth_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'hF0, 8'h0F, 8'hC3));
		send_request(depth_pixel(12'h000, 12'h000, 16'hFFFF, 8'h3C, 8'h99, 8'h66));
	endtask

	// plain VGA-like camera, identity pose restored
	task automatic test_identity_pose();
		set_intrinsics(16'd5112, 16'd3832, 24'd31957, 24'd31957, 32'd858993);
		send_request(pose_word(PIDX_QW, 24'sd65536));
		send_request(pose_word(PIDX_QX, 24'sd0));
		send_request(pose_word(PIDX_QY, 24'sd0));
		send_request(pose_word(PIDX_QZ, 24'sd0));
		send_request(pose_word(PIDX_TX, 24'sd0));
		send_request(pose_word(PIDX_TY, 24'sd0));
		send_request(pose_word(PIDX_TZ, 24'sd0));
		send_request(depth_pixel(12'd320, 12'd240, 16'd5000, 8'h80, 8'h80, 8'h80));
		send_request(depth_pixel(12'd639, 12'd0, 16'd20000, 8'h01, 8'h02, 8'h04));
	endtask

	// Mostly pixels under the current intrinsics, with whole pose updates
	// mixed in; the rest is stray pose words and empty pixels. The count
	// excludes requests the block drops.
	task automatic test_random_stream(int target);
		int counted, pick;
		logic [2:0] idx;
		logic [15:0] d;
		counted = 0;
		while (counted < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				load_random_pose();
				counted += 7;
			end else if (pick < 9) begin
				idx = 3'($urandom_range(0, 7));
				send_request(pose_word(idx, TW'($urandom())));
				if (idx != PIDX_UNUSED)
					counted++;
			end else if (pick < 13) begin
				send_request(depth_pixel(12'($urandom()), 12'($urandom()), 16'd0,
					8'($urandom()), 8'($urandom()), 8'($urandom())));
			end else if (pick < 14) begin
				// hold off until every expected point has come out
				wait_points_drained();
			end else begin
				d = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(300, 20000))
					: 16'($urandom_range(1, 65535));
				send_request(depth_pixel(12'($urandom()), 12'($urandom()), d,
					8'($urandom()), 8'($urandom()), 8'($urandom())));
				counted++;
			end
		end
	endtask

	// random phases under several intrinsic sets, extremes included
	task automatic test_random_phases();
		test_random_stream(340);
		set_intrinsics(16'd10240, 16'd5760, 24'd18641, 24'd18641, 32'd4294967);
		test_random_stream(340);
		set_intrinsics(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
		test_random_stream(340);
		set_intrinsics(16'h0000, 16'h0000, 24'h000000, 24'h000000, 32'h00000000);
		test_random_stream(340);
		set_intrinsics(16'($urandom()), 16'($urandom()), 24'($urandom()), 24'($urandom()),
			$urandom());
		test_random_stream(340);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		principal_u      = 0;
		principal_v      = 0;
		recip_fx         = 0;
		recip_fy         = 0;
		metres_per_count = 0;
		pose_q           = '{65536, 0, 0, 0};
		pose_t           = '{0, 0, 0};
		fault_count      = 0;
		cycle_count      = 0;
		send_unpaced     = 1'b0;
		sink_unpaced     = 1'b0;

		arst_n              <= 1'b0;
		pixel_ch.valid      <= 1'b0;
		pixel_ch.kind       <= KIND_POSE;
		pixel_ch.pose_index <= PIDX_QW;
		pixel_ch.pose_value <= '0;
		pixel_ch.column     <= '0;
		pixel_ch.row        <= '0;
		pixel_ch.depth      <= '0;
		pixel_ch.red        <= '0;
		pixel_ch.green      <= '0;
		pixel_ch.blue       <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= CFG_CENTER_X;
		cfg_ch.data         <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_config();
		test_pose_words();
		test_config_extremes();
		test_identity_pose();
		test_random_phases();

		wait_idle();
		if (fault_count == 0)
			$display("depth_pixel_backproject verification clean");
		else
			$display("depth_pixel_backproject verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/dpb_pkg.sv
rtl/core/dpb_ifs.sv
rtl/core/dpb_cam.sv
rtl/core/dpb_rot.sv
rtl/core/dpb_world.sv
rtl/core/depth_pixel_backproject.sv
tb/sv/tb.sv
